@@ rtl/seven_segment_text_frame_builder_assert.svh @@
// Assertion macros for the seven-segment frame builder checker.
// Needs clk and rst_n in scope wherever a macro is used.
`ifndef SEVEN_SEGMENT_TEXT_FRAME_BUILDER_ASSERT_SVH
`define SEVEN_SEGMENT_TEXT_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, ignored while in reset
`define SSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset
`define SSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ssd_pkg.sv @@
// Shared types, codes, font and fixed frame table for the frame builder.
// No dependencies.
package ssd_pkg;

  // input op codes
  localparam logic [2:0] OP_PRINT  = 3'd0;
  localparam logic [2:0] OP_CURSOR = 3'd1;
  localparam logic [2:0] OP_PUT    = 3'd2;
  localparam logic [2:0] OP_FLUSH  = 3'd3;
  localparam logic [2:0] OP_INIT   = 3'd4;
  localparam logic [2:0] OP_SHUT   = 3'd5;
  localparam logic [2:0] OP_INTEN  = 3'd6;

  // classified command kinds in the queue
  localparam logic [2:0] CMD_PRINT  = 3'd0;
  localparam logic [2:0] CMD_POINT  = 3'd1;
  localparam logic [2:0] CMD_CURSOR = 3'd2;
  localparam logic [2:0] CMD_PUT    = 3'd3;
  localparam logic [2:0] CMD_FLUSH  = 3'd4;
  localparam logic [2:0] CMD_INIT   = 3'd5;
  localparam logic [2:0] CMD_SHUT   = 3'd6;
  localparam logic [2:0] CMD_INTEN  = 3'd7;

  // controller register addresses
  localparam logic [3:0] REG_DECODE    = 4'h9;
  localparam logic [3:0] REG_INTENSITY = 4'hA;
  localparam logic [3:0] REG_SCAN      = 4'hB;
  localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
  localparam logic [3:0] REG_TEST      = 4'hF;

  localparam logic [7:0] SCAN_ALL  = 8'h07;
  localparam logic [7:0] RUN_MODE  = 8'h01;
  localparam logic [6:0] DASH_SEG  = 7'h01;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  // init sequence length and frame counter width
  localparam int unsigned INIT_FRAMES = 14;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned BUF_DEPTH   = 8;
  localparam int unsigned BUF_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] arg;   // glyph or level data
    logic [2:0] pos;   // digit or cursor value
  } cmd_t;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
  } frame_t;

  // character code to segments (g in bit 0, a in bit 6)
  function automatic logic [6:0] glyph(input logic [7:0] code);
    logic [6:0] seg;
    case (code)
      8'h30: seg = 7'h7E;  8'h31: seg = 7'h30;  8'h32: seg = 7'h6D;
      8'h33: seg = 7'h79;  8'h34: seg = 7'h33;  8'h35: seg = 7'h5B;
      8'h36: seg = 7'h5F;  8'h37: seg = 7'h70;  8'h38: seg = 7'h7F;
      8'h39: seg = 7'h7B;
      8'h20: seg = 7'h00;  // space
      8'h41: seg = 7'h77;  8'h42: seg = 7'h1F;  8'h43: seg = 7'h4E;
      8'h44: seg = 7'h3D;  8'h45: seg = 7'h4F;  8'h46: seg = 7'h47;
      8'h47: seg = 7'h5E;  8'h48: seg = 7'h37;  8'h4A: seg = 7'h3C;
      8'h4C: seg = 7'h0E;  8'h4E: seg = 7'h15;  8'h4F: seg = 7'h1D;
      8'h50: seg = 7'h67;  8'h51: seg = 7'h73;  8'h52: seg = 7'h05;
      8'h54: seg = 7'h0F;  8'h55: seg = 7'h3E;  8'h59: seg = 7'h3B;
      8'h61: seg = 7'h77;  8'h62: seg = 7'h1F;  8'h63: seg = 7'h0D;
      8'h64: seg = 7'h3D;  8'h65: seg = 7'h4F;  8'h66: seg = 7'h47;
      8'h67: seg = 7'h5E;  8'h68: seg = 7'h17;  8'h6A: seg = 7'h3C;
      8'h6C: seg = 7'h0E;  8'h6E: seg = 7'h15;  8'h6F: seg = 7'h1D;
      8'h70: seg = 7'h67;  8'h71: seg = 7'h73;  8'h72: seg = 7'h05;
      8'h74: seg = 7'h0F;  8'h75: seg = 7'h1C;  8'h79: seg = 7'h3B;
      default: seg = DASH_SEG;
    endcase
    return seg;
  endfunction

  // fixed init sequence, one frame per index
  function automatic frame_t init_frame(input logic [IDX_W-1:0] idx);
    frame_t f;
    f.data = 8'h00;
    case (idx)
      4'd0:    f.addr = REG_SHUTDOWN;
      4'd1:    f.addr = REG_DECODE;
      4'd2:    f.addr = REG_INTENSITY;
      4'd3:    begin
        f.addr = REG_SCAN;
        f.data = SCAN_ALL;
      end
      4'd4:    f.addr = REG_TEST;
      4'd13:   begin
        f.addr = REG_SHUTDOWN;
        f.data = RUN_MODE;
      end
      default: f.addr = idx - 4'd4;  // digit registers 1..8
    endcase
    return f;
  endfunction

endpackage

@@ rtl/ssd_front.sv @@
// Front end: accepts input items and classifies them into queue commands.
// Depends on ssd_pkg.
module ssd_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,
  input  logic [2:0]        in_tuser,
  input  logic              q_full,
  output logic              q_push,
  output ssd_pkg::cmd_t     q_cmd
);

  logic [7:0] char_code;
  logic [2:0] position;
  logic [3:0] level;
  logic       known;

  assign char_code = in_tdata[7:0];
  assign position  = in_tdata[10:8];
  assign level     = in_tdata[14:11];
  assign in_tready = !q_full;

  // decode op into a command; the unused op is accepted and dropped
  always_comb begin
    known       = 1'b1;
    q_cmd.pos   = position;
    q_cmd.arg   = {1'b0, ssd_pkg::glyph(char_code)};
    q_cmd.kind  = ssd_pkg::CMD_PRINT;
    case (in_tuser)
      ssd_pkg::OP_PRINT: begin
        q_cmd.kind = (char_code == ssd_pkg::CHAR_DOT) ? ssd_pkg::CMD_POINT
                                                       : ssd_pkg::CMD_PRINT;
      end
      ssd_pkg::OP_CURSOR: q_cmd.kind = ssd_pkg::CMD_CURSOR;
      ssd_pkg::OP_PUT:    q_cmd.kind = ssd_pkg::CMD_PUT;
      ssd_pkg::OP_FLUSH:  q_cmd.kind = ssd_pkg::CMD_FLUSH;
      ssd_pkg::OP_INIT:   q_cmd.kind = ssd_pkg::CMD_INIT;
      ssd_pkg::OP_SHUT: begin
        q_cmd.kind = ssd_pkg::CMD_SHUT;
        q_cmd.arg  = {7'b0, level[0]};
      end
      ssd_pkg::OP_INTEN: begin
        q_cmd.kind = ssd_pkg::CMD_INTEN;
        q_cmd.arg  = {4'b0, level};
      end
      default: known = 1'b0;
    endcase
  end

  assign q_push = in_tvalid && !q_full && known;

endmodule

@@ rtl/ssd_queue.sv @@
// Short command queue between front and back ends.
// Depends on ssd_pkg.
module ssd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ssd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output ssd_pkg::cmd_t head
);

  localparam int unsigned PTR_W = $clog2(ssd_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(ssd_pkg::QUEUE_DEPTH + 1);

  ssd_pkg::cmd_t    mem_r [ssd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(ssd_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(ssd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(ssd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/ssd_back.sv @@
// Back end: holds digit buffer and cursor, executes commands, emits frames.
// Depends on ssd_pkg.
module ssd_back #(
  parameter int unsigned DIGITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  ssd_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata,
  output logic          out_tlast
);

  localparam int unsigned IW = ssd_pkg::IDX_W;
  localparam int unsigned BW = ssd_pkg::BUF_IDX_W;

  // digit store: segments and decimal points kept apart
  logic [6:0]     seg_r [ssd_pkg::BUF_DEPTH];
  logic [ssd_pkg::BUF_DEPTH-1:0] dp_r;
  logic [7:0]     cursor_r;

  // frame sequencer
  logic           busy_r;
  logic [2:0]     kind_r;
  logic [7:0]     arg_r;
  logic [IW-1:0]  idx_r;

  // output register
  logic           out_valid_r;
  ssd_pkg::frame_t out_frame_r;
  logic           out_last_r;

  ssd_pkg::frame_t frame;
  logic           frame_last;
  logic           slot_free;
  logic           emit;
  logic [BW-1:0]  rd_idx;
  logic [BW-1:0]  prev_idx;

  assign slot_free = !out_valid_r || out_tready;
  assign emit      = busy_r && slot_free;
  assign q_pop     = !busy_r && q_valid;
  assign rd_idx    = idx_r[BW-1:0];
  assign prev_idx  = cursor_r[BW-1:0] - 1'b1;

  // current frame of the running command
  always_comb begin
    frame.addr = ssd_pkg::REG_SHUTDOWN;
    frame.data = arg_r;
    frame_last = 1'b1;
    case (kind_r)
      ssd_pkg::CMD_FLUSH: begin
        frame.addr = IW'(DIGITS) - idx_r;
        frame.data = {dp_r[rd_idx], seg_r[rd_idx]};
        frame_last = (idx_r == IW'(DIGITS - 1));
      end
      ssd_pkg::CMD_INIT: begin
        frame      = ssd_pkg::init_frame(idx_r);
        frame_last = (idx_r == IW'(ssd_pkg::INIT_FRAMES - 1));
      end
      ssd_pkg::CMD_SHUT:  frame.addr = ssd_pkg::REG_SHUTDOWN;
      ssd_pkg::CMD_INTEN: frame.addr = ssd_pkg::REG_INTENSITY;
      default: frame.addr = ssd_pkg::REG_SHUTDOWN;
    endcase
  end

  // command execution and sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      kind_r   <= ssd_pkg::CMD_PRINT;
      idx_r    <= '0;
      cursor_r <= '0;
      dp_r     <= '0;
      for (int i = 0; i < ssd_pkg::BUF_DEPTH; i++) begin
        seg_r[i] <= '0;
      end
    end else if (q_pop) begin
      case (q_head.kind)
        ssd_pkg::CMD_PRINT: begin
          seg_r[cursor_r[BW-1:0]] <= q_head.arg[6:0];
          cursor_r <= cursor_r + 1'b1;
        end
        ssd_pkg::CMD_POINT: begin
          if (cursor_r != '0) begin
            dp_r[prev_idx] <= 1'b1;
          end
        end
        ssd_pkg::CMD_CURSOR: cursor_r <= {5'b0, q_head.pos};
        ssd_pkg::CMD_PUT:    seg_r[q_head.pos] <= q_head.arg[6:0];
        default: begin
          busy_r <= 1'b1;
          kind_r <= q_head.kind;
          idx_r  <= '0;
        end
      endcase
    end else if (emit) begin
      idx_r <= idx_r + 1'b1;
      if (frame_last) begin
        busy_r <= 1'b0;
        // flush clears the buffer once the last digit has gone out
        if (kind_r == ssd_pkg::CMD_FLUSH) begin
          dp_r <= '0;
          for (int i = 0; i < ssd_pkg::BUF_DEPTH; i++) begin
            seg_r[i] <= '0;
          end
        end
      end
    end
  end

  // command argument, payload only
  always_ff @(posedge clk) begin
    if (q_pop) begin
      arg_r <= q_head.arg;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_frame_r <= frame;
      out_last_r  <= frame_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_frame_r.data, out_frame_r.addr};
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/seven_segment_text_frame_builder.sv @@
// Channel   Dir  Payload
// in_*      in   tuser: op[2:0]; tdata: char_code[7:0] position[10:8] level[14:11]
// out_*     out  tdata: reg_addr[3:0] reg_data[11:4]; tlast: last frame of item
//
// Character and cursor ops retire in the back end as they are popped; the
// unused op is accepted and dropped by the front end.
// Flush emits DIGITS frames, init 14, shutdown and intensity one, at one frame
// per cycle from the back-end sequencer while the output is not stalled.
// A two-entry command queue lets the front accept while frames are in flight.
// Reset (rst_n low, synchronous) clears buffer, cursor, queue and output valid.
// A stalled output holds its frame; the queue fills and in_tready drops.
// Top level: instantiates ssd_front, ssd_queue and ssd_back; uses ssd_pkg.
module seven_segment_text_frame_builder #(
  parameter int unsigned DIGITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // char_code[7:0], position[10:8], level[14:11]
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // reg_addr[3:0], reg_data[11:4]
  output logic        out_tlast
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  ssd_pkg::cmd_t push_cmd;
  ssd_pkg::cmd_t head_cmd;

  ssd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  ssd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (head_cmd)
  );

  ssd_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/ssd_checker.sv @@
// Port-level checks on the frame builder, bound to the top level.
// Depends on ssd_pkg and seven_segment_text_frame_builder_assert.svh.
`include "seven_segment_text_frame_builder_assert.svh"

module ssd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  logic [3:0] addr;
  logic [7:0] data;

  assign addr = out_tdata[3:0];
  assign data = out_tdata[11:4];

  // a stalled frame holds
  `SSD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "frame changed while stalled")

  // only digit or known control registers are addressed, padding stays zero
  `SSD_ASSERT_IMP(a_addr_legal, out_tvalid, addr != 4'h0 && addr != 4'hD && addr != 4'hE && out_tdata[15:12] == 4'h0, "illegal frame address")

  // scan limit only inside init, always all digits
  `SSD_ASSERT_IMP(a_scan_frame, out_tvalid && addr == ssd_pkg::REG_SCAN, data == ssd_pkg::SCAN_ALL && !out_tlast, "bad scan limit frame")

  // decode mode and display test are always written as zero
  `SSD_ASSERT_IMP(a_fixed_zero, out_tvalid && (addr == ssd_pkg::REG_DECODE || addr == ssd_pkg::REG_TEST), data == 8'h00 && !out_tlast, "bad fixed control frame")

endmodule

bind seven_segment_text_frame_builder ssd_checker u_ssd_checker (.*);

@@ bench/tb_seven_segment_text_frame_builder.sv @@
// Self-checking bench for the seven-segment text frame builder: a directed
// table, then random text lines and control bursts under several idle mixes.
// Depends on ssd_pkg and the seven_segment_text_frame_builder top level.
module tb_seven_segment_text_frame_builder;

  localparam int unsigned NUM_DIGITS = 8;
  localparam logic [2:0]  OP_SPARE   = 3'd7;  // unused op, ignored by the block
  localparam logic [7:0]  DP_MASK    = 8'h80;
  localparam int          QUIET_MAX  = 4000;  // cycles without any item moving
  localparam int          N_DIRECTED = 23;
  localparam int          PHASE_ITEMS = 16;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } frame_s;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] code;
    logic [2:0] pos;
    logic [3:0] level;
    logic       fixed;     // expected frames typed in below
    logic [3:0] exp_addr;
    logic [7:0] exp_data;
  } row_s;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // char_code[7:0], position[10:8], level[14:11]
  logic [2:0]  in_tuser;   // op[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // reg_addr[3:0], reg_data[11:4]
  logic        out_tlast;

  // predicted display state
  logic [7:0] seg_buf [NUM_DIGITS];
  logic [7:0] cur_pos;

  frame_s frame_q [$];   // frames still owed by the block
  frame_s staged [$];    // frames of the item just predicted

  int fail_count = 0;
  int counted    = 0;
  int quiet      = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;

  seven_segment_text_frame_builder #(.DIGITS(NUM_DIGITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // font: {character code, segments a..g}
  function automatic logic [14:0] font_entry(input int k);
    logic [14:0] e;
    case (k)
      0:  e = {8'h30, 7'h7E};  1:  e = {8'h31, 7'h30};  2:  e = {8'h32, 7'h6D};
      3:  e = {8'h33, 7'h79};  4:  e = {8'h34, 7'h33};  5:  e = {8'h35, 7'h5B};
      6:  e = {8'h36, 7'h5F};  7:  e = {8'h37, 7'h70};  8:  e = {8'h38, 7'h7F};
      9:  e = {8'h39, 7'h7B};  10: e = {8'h20, 7'h00};  11: e = {8'h41, 7'h77};
      12: e = {8'h42, 7'h1F};  13: e = {8'h43, 7'h4E};  14: e = {8'h44, 7'h3D};
      15: e = {8'h45, 7'h4F};  16: e = {8'h46, 7'h47};  17: e = {8'h47, 7'h5E};
      18: e = {8'h48, 7'h37};  19: e = {8'h4A, 7'h3C};  20: e = {8'h4C, 7'h0E};
      21: e = {8'h4E, 7'h15};  22: e = {8'h4F, 7'h1D};  23: e = {8'h50, 7'h67};
      24: e = {8'h51, 7'h73};  25: e = {8'h52, 7'h05};  26: e = {8'h54, 7'h0F};
      27: e = {8'h55, 7'h3E};  28: e = {8'h59, 7'h3B};  29: e = {8'h61, 7'h77};
      30: e = {8'h62, 7'h1F};  31: e = {8'h63, 7'h0D};  32: e = {8'h64, 7'h3D};
      33: e = {8'h65, 7'h4F};  34: e = {8'h66, 7'h47};  35: e = {8'h67, 7'h5E};
      36: e = {8'h68, 7'h17};  37: e = {8'h6A, 7'h3C};  38: e = {8'h6C, 7'h0E};
      39: e = {8'h6E, 7'h15};  40: e = {8'h6F, 7'h1D};  41: e = {8'h70, 7'h67};
      42: e = {8'h71, 7'h73};  43: e = {8'h72, 7'h05};  44: e = {8'h74, 7'h0F};
      45: e = {8'h75, 7'h1C};  default: e = {8'h79, 7'h3B};
    endcase
    return e;
  endfunction

  function automatic logic [6:0] segments_of(input logic [7:0] code);
    logic [14:0] e;
    for (int k = 0; k < 47; k++) begin
      e = font_entry(k);
      if (e[14:7] == code) return e[6:0];
    end
    return ssd_pkg::DASH_SEG;
  endfunction

  function automatic void stage_frame(input logic [3:0] addr, input logic [7:0] data);
    frame_s f;
    f.addr = addr;
    f.data = data;
    f.last = 1'b0;
    staged.push_back(f);
  endfunction

  // work out the frames of one accepted item and update the display state
  function automatic void predict_frames(input logic [2:0] op, input logic [7:0] code,
                                         input logic [2:0] pos, input logic [3:0] level);
    logic [7:0] prev;
    frame_s     f;
    staged.delete();
    case (op)
      ssd_pkg::OP_PRINT: begin
        if (code == ssd_pkg::CHAR_DOT) begin
          // point goes on the digit before the cursor, cursor stays
          if (cur_pos != 8'd0) begin
            prev = cur_pos - 8'd1;
            seg_buf[prev[2:0]] = seg_buf[prev[2:0]] | DP_MASK;
          end
        end else begin
          seg_buf[cur_pos[2:0]] = {seg_buf[cur_pos[2:0]][7], segments_of(code)};
          cur_pos = cur_pos + 8'd1;
        end
      end
      ssd_pkg::OP_CURSOR: cur_pos = {5'd0, pos};
      ssd_pkg::OP_PUT:    seg_buf[pos] = {seg_buf[pos][7], segments_of(code)};
      ssd_pkg::OP_FLUSH: begin
        for (int k = 0; k < NUM_DIGITS; k++) stage_frame(4'(NUM_DIGITS - k), seg_buf[k]);
        for (int k = 0; k < NUM_DIGITS; k++) seg_buf[k] = 8'h00;
      end
      ssd_pkg::OP_INIT: begin
        stage_frame(ssd_pkg::REG_SHUTDOWN, 8'h00);
        stage_frame(ssd_pkg::REG_DECODE, 8'h00);
        stage_frame(ssd_pkg::REG_INTENSITY, 8'h00);
        stage_frame(ssd_pkg::REG_SCAN, ssd_pkg::SCAN_ALL);
        stage_frame(ssd_pkg::REG_TEST, 8'h00);
        for (int k = 1; k <= 8; k++) stage_frame(4'(k), 8'h00);
        stage_frame(ssd_pkg::REG_SHUTDOWN, ssd_pkg::RUN_MODE);
      end
      ssd_pkg::OP_SHUT:  stage_frame(ssd_pkg::REG_SHUTDOWN, {7'd0, level[0]});
      ssd_pkg::OP_INTEN: stage_frame(ssd_pkg::REG_INTENSITY, {4'd0, level});
      default: ;
    endcase
    if (staged.size() > 0) begin
      f = staged.pop_back();
      f.last = 1'b1;
      staged.push_back(f);
    end
  endfunction

  // present one item, with random idle cycles ahead of it, until taken
  task automatic send_item(input logic [2:0] op, input logic [7:0] code,
                           input logic [2:0] pos, input logic [3:0] level);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, level, pos, code};
    do @(posedge clk); while (!in_tready);
    if (op != OP_SPARE) counted++;
  endtask

  task automatic issue(input logic [2:0] op, input logic [7:0] code,
                       input logic [2:0] pos, input logic [3:0] level);
    send_item(op, code, pos, level);
    predict_frames(op, code, pos, level);
    while (staged.size() > 0) frame_q.push_back(staged.pop_front());
  endtask

  function automatic row_s directed_row(input int i);
    row_s r;
    case (i)
      // buffer empty after reset
      0:  r = '{ssd_pkg::OP_FLUSH, 8'h00, 3'd0, 4'h0, 1'b1, 4'h0, 8'h00};
      1:  r = '{ssd_pkg::OP_SHUT, 8'h00, 3'd0, 4'hE, 1'b1, ssd_pkg::REG_SHUTDOWN, 8'h00};
      2:  r = '{ssd_pkg::OP_SHUT, 8'hFF, 3'd7, 4'h1, 1'b1, ssd_pkg::REG_SHUTDOWN, 8'h01};
      3:  r = '{ssd_pkg::OP_INTEN, 8'h00, 3'd0, 4'h0, 1'b1, ssd_pkg::REG_INTENSITY, 8'h00};
      4:  r = '{ssd_pkg::OP_INTEN, 8'hFF, 3'd7, 4'hF, 1'b1, ssd_pkg::REG_INTENSITY, 8'h0F};
      5:  r = '{ssd_pkg::OP_INIT, 8'hFF, 3'd7, 4'hF, 1'b0, 4'h0, 8'h00};
      // point with cursor at zero
      6:  r = '{ssd_pkg::OP_PRINT, ssd_pkg::CHAR_DOT, 3'd0, 4'h0, 1'b0, 4'h0, 8'h00};
      7:  r = '{ssd_pkg::OP_PRINT, 8'h38, 3'd5, 4'h3, 1'b0, 4'h0, 8'h00};
      8:  r = '{ssd_pkg::OP_PRINT, ssd_pkg::CHAR_DOT, 3'd0, 4'h0, 1'b0, 4'h0, 8'h00};
      9:  r = '{ssd_pkg::OP_PRINT, ssd_pkg::CHAR_DOT, 3'd7, 4'hF, 1'b0, 4'h0, 8'h00};
      // keeps the point
      10: r = '{ssd_pkg::OP_PUT, 8'h30, 3'd0, 4'h0, 1'b0, 4'h0, 8'h00};
      // dot by position: dash
      11: r = '{ssd_pkg::OP_PUT, ssd_pkg::CHAR_DOT, 3'd7, 4'h0, 1'b0, 4'h0, 8'h00};
      12: r = '{ssd_pkg::OP_PUT, 8'hFF, 3'd3, 4'hF, 1'b0, 4'h0, 8'h00};
      13: r = '{ssd_pkg::OP_PUT, 8'h00, 3'd5, 4'h0, 1'b0, 4'h0, 8'h00};
      14: r = '{ssd_pkg::OP_PUT, 8'h20, 3'd6, 4'h5, 1'b0, 4'h0, 8'h00};
      15: r = '{ssd_pkg::OP_CURSOR, 8'h00, 3'd7, 4'h0, 1'b0, 4'h0, 8'h00};
      16: r = '{ssd_pkg::OP_PRINT, 8'h41, 3'd0, 4'h0, 1'b0, 4'h0, 8'h00};
      // cursor past the buffer
      17: r = '{ssd_pkg::OP_PRINT, 8'h75, 3'd2, 4'hA, 1'b0, 4'h0, 8'h00};
      18: r = '{ssd_pkg::OP_PRINT, ssd_pkg::CHAR_DOT, 3'd0, 4'h0, 1'b0, 4'h0, 8'h00};
      // unused op
      19: r = '{OP_SPARE, 8'hFF, 3'd7, 4'hF, 1'b0, 4'h0, 8'h00};
      20: r = '{ssd_pkg::OP_FLUSH, 8'hFF, 3'd7, 4'hF, 1'b0, 4'h0, 8'h00};
      // cleared by last flush
      21: r = '{ssd_pkg::OP_FLUSH, 8'h00, 3'd0, 4'h0, 1'b1, 4'h0, 8'h00};
      default: r = '{ssd_pkg::OP_CURSOR, 8'h00, 3'd0, 4'h0, 1'b0, 4'h0, 8'h00};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pick_char();
    int          r;
    logic [14:0] e;
    r = $urandom_range(0, 99);
    e = font_entry($urandom_range(0, 46));
    if (r < 60) return e[14:7];
    if (r < 75) return ssd_pkg::CHAR_DOT;
    return 8'($urandom);
  endfunction

  // one random burst: mostly text lines, some control ops, some noise
  task automatic random_burst();
    int         kind;
    int         n;
    logic [7:0] c;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      if ($urandom_range(0, 3) != 0)
        issue(ssd_pkg::OP_CURSOR, 8'($urandom), 3'($urandom), 4'($urandom));
      n = $urandom_range(1, 10);
      repeat (n) begin
        c = pick_char();
        if ($urandom_range(0, 99) < 15)
          issue(ssd_pkg::OP_PUT, c, 3'($urandom), 4'($urandom));
        else
          issue(ssd_pkg::OP_PRINT, c, 3'($urandom), 4'($urandom));
      end
      if ($urandom_range(0, 3) != 0)
        issue(ssd_pkg::OP_FLUSH, 8'($urandom), 3'($urandom), 4'($urandom));
    end else if (kind <= 7) begin
      case ($urandom_range(0, 2))
        0:       issue(ssd_pkg::OP_SHUT, 8'($urandom), 3'($urandom), 4'($urandom));
        1:       issue(ssd_pkg::OP_INTEN, 8'($urandom), 3'($urandom), 4'($urandom));
        default: issue(ssd_pkg::OP_INIT, 8'($urandom), 3'($urandom), 4'($urandom));
      endcase
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) issue(3'($urandom), 8'($urandom), 3'($urandom), 4'($urandom));
    end
  endtask

  // receiver: check each frame taken, then choose next ready
  always @(posedge clk) begin
    frame_s want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      quiet      <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frame_q.size() == 0) begin
          $display("%0t: expected no frame, got addr %h data %h last %b", $time,
                   out_tdata[3:0], out_tdata[11:4], out_tlast);
          fail_count++;
        end else begin
          want = frame_q.pop_front();
          if (out_tdata[3:0] !== want.addr || out_tdata[11:4] !== want.data ||
              out_tlast !== want.last) begin
            $display("%0t: expected addr %h data %h last %b, got addr %h data %h last %b",
                     $time, want.addr, want.data, want.last,
                     out_tdata[3:0], out_tdata[11:4], out_tlast);
            fail_count++;
          end
        end
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog on a stuck handshake
  initial begin
    wait (rst_n);
    while (quiet < QUIET_MAX) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // stimulus
  initial begin
    row_s       r;
    frame_s     f;
    int         target;
    logic [7:0] c;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 16'h0000;
    in_tuser  = ssd_pkg::OP_PRINT;
    cur_pos   = 8'd0;
    for (int k = 0; k < NUM_DIGITS; k++) seg_buf[k] = 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      r = directed_row(i);
      send_item(r.op, r.code, r.pos, r.level);
      predict_frames(r.op, r.code, r.pos, r.level);
      if (r.fixed) begin
        staged.delete();
        if (r.op == ssd_pkg::OP_FLUSH) begin
          for (int k = 0; k < NUM_DIGITS; k++) begin
            f.addr = 4'(NUM_DIGITS - k);
            f.data = r.exp_data;
            f.last = (k == NUM_DIGITS - 1);
            frame_q.push_back(f);
          end
        end else begin
          f.addr = r.exp_addr;
          f.data = r.exp_data;
          f.last = 1'b1;
          frame_q.push_back(f);
        end
      end else begin
        while (staged.size() > 0) frame_q.push_back(staged.pop_front());
      end
    end

    // random phases with different idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 79; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      if (ph == 0) begin
        // cursor runs all the way round to zero, then a point there does nothing
        issue(ssd_pkg::OP_CURSOR, 8'($urandom), 3'd0, 4'($urandom));
        repeat (256) begin
          c = pick_char();
          if (c == ssd_pkg::CHAR_DOT) c = 8'h2D;
          issue(ssd_pkg::OP_PRINT, c, 3'($urandom), 4'($urandom));
        end
        issue(ssd_pkg::OP_PRINT, ssd_pkg::CHAR_DOT, 3'($urandom), 4'($urandom));
        issue(ssd_pkg::OP_PRINT, pick_char(), 3'($urandom), 4'($urandom));
        issue(ssd_pkg::OP_PRINT, ssd_pkg::CHAR_DOT, 3'($urandom), 4'($urandom));
        issue(ssd_pkg::OP_FLUSH, 8'($urandom), 3'($urandom), 4'($urandom));
      end
      target = counted + PHASE_ITEMS;
      while (counted < target) random_burst();
    end
    in_tvalid <= 1'b0;

    // drain and let the back end settle
    while (frame_q.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ seven_segment_text_frame_builder.f @@
+incdir+rtl
rtl/ssd_pkg.sv
rtl/ssd_front.sv
rtl/ssd_queue.sv
rtl/ssd_back.sv
rtl/seven_segment_text_frame_builder.sv
rtl/ssd_checker.sv
bench/tb_seven_segment_text_frame_builder.sv
